/* hdl/gmo_pkg.sv */
`default_nettype none
package gmo_pkg;

	// Configuration register map
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam int CFG_DATA_W = 13;
	localparam int FW_BITS    = 11;
	localparam int FH_BITS    = 13;
	localparam logic [FW_BITS-1:0] FW_RESET = 11'd640;
	localparam logic [FH_BITS-1:0] FH_RESET = 13'd480;

	localparam int MAX_HEIGHT = 4096;
	localparam int ROW_W      = 12;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_PIXEL_BITS = 16;

	// Job queue between front and back
	localparam int QDEPTH       = 8;
	localparam int QPTR_W       = 3;
	localparam int MAX_PER_ITEM = 3;
	localparam int PUSH_W       = 2;

	// Orientation arithmetic (turn fractions in Q.32, ratio in Q.30)
	localparam int ORI_W     = 16;
	localparam int FRAC      = 30;
	localparam int DIV_STEPS = 31;
	localparam logic [31:0] K1        = 32'd124477236;
	localparam logic [31:0] K2        = 32'd661349404;
	localparam logic [31:0] BASE_POS  = 32'h2000_0000;
	localparam logic [31:0] BASE_NEG  = 32'h6000_0000;
	localparam logic [31:0] ROUND_ORI = 32'h0000_8000;

	typedef struct packed {
		logic room;
		logic avail;
	} q_status_t;

endpackage
`default_nettype wire

/* hdl/gmo_queue.sv */
`default_nettype none
module gmo_queue #(
	parameter int DATA_W = 8
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic [gmo_pkg::PUSH_W-1:0]                     push_num,
	input  wire logic [gmo_pkg::MAX_PER_ITEM*DATA_W-1:0]        push_data,
	input  wire logic                                           pop,
	output gmo_pkg::q_status_t                                  status,
	output logic [DATA_W-1:0]                                   head
);

	localparam int QD = gmo_pkg::QDEPTH;
	localparam int PW = gmo_pkg::QPTR_W;

	logic [DATA_W-1:0] mem_q [QD];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [PW:0]       cnt_q;

	assign status.room  = cnt_q <= (PW+1)'(QD - gmo_pkg::MAX_PER_ITEM);
	assign status.avail = cnt_q != '0;
	assign head = mem_q[rd_q];

	// Store up to three jobs per beat in order
	always_ff @(posedge clk) begin
		for (int k = 0; k < gmo_pkg::MAX_PER_ITEM; k++) begin
			if (PW'(k) < PW'(push_num))
				mem_q[wr_q + PW'(k)] <= push_data[k*DATA_W +: DATA_W];
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(push_num);
			rd_q  <= rd_q + PW'(pop);
			cnt_q <= cnt_q + (PW+1)'(push_num) - (PW+1)'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(QD))
		else $error("job queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_num != '0) |-> (cnt_q + (PW+1)'(push_num) <= (PW+1)'(QD)))
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> status.avail)
		else $error("job queue popped while empty");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_q == rd_q))
		else $error("job queue pointers disagree with count");

endmodule
`default_nettype wire

/* hdl/gmo_front.sv */
`default_nettype none
module gmo_front #(
	parameter int MAX_WIDTH  = gmo_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = gmo_pkg::DEF_PIXEL_BITS
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   pix_valid,
	output logic                                        pix_ready,
	input  wire logic [PIXEL_BITS-1:0]                  pixel,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]           wm1,
	input  wire logic [gmo_pkg::ROW_W-1:0]              hm1,
	input  wire gmo_pkg::q_status_t                     qstat,
	output logic [gmo_pkg::PUSH_W-1:0]                  push_num,
	output logic [gmo_pkg::MAX_PER_ITEM*(2*(PIXEL_BITS+2)+$clog2(MAX_WIDTH)
		+gmo_pkg::ROW_W+1)-1:0]                         push_data
);

	localparam int P     = PIXEL_BITS;
	localparam int G     = P + 2;
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = gmo_pkg::ROW_W;
	localparam int DEPTH = 2**CW;
	localparam int JW    = 2*G + CW + RW + 1;

	function automatic logic signed [G-1:0] dif(input logic [P-1:0] a, input logic [P-1:0] b);
		dif = $signed({2'b00, a}) - $signed({2'b00, b});
	endfunction

	function automatic logic signed [G-1:0] dbl(input logic signed [G-1:0] d);
		dbl = d <<< 1;
	endfunction

	logic [P-1:0]  newer_mem [DEPTH];
	logic [P-1:0]  older_mem [DEPTH];
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [P-1:0]  h0_q, h1_q, wprev_q, wcur_q, l0_q, l1_q, nrd_q, ord_q;

	logic          accept;
	logic [CW-1:0] c;
	logic [RW-1:0] r;
	logic          at_c0, at_c1, at_cl, at_r1, at_rl;
	logic [P-1:0]  cur, nxt;
	logic signed [G-1:0] gx_a, gy_a, gx_b, gy_b, gx_c, gy_c;
	logic          val_a, val_b, val_c;
	logic [JW-1:0] job_a, job_b, job_c;

	assign pix_ready = qstat.room;
	assign accept    = pix_valid && qstat.room;

	// Position of this pixel, folded into the current frame size
	always_comb begin
		c     = (col_q > wm1) ? wm1 : col_q;
		r     = (row_q > hm1) ? hm1 : row_q;
		at_c0 = c == '0;
		at_c1 = c == CW'(1);
		at_cl = c == wm1;
		at_r1 = r == RW'(1);
		at_rl = r == hm1;
		cur   = at_c0 ? h0_q : wcur_q;
		nxt   = at_c0 ? h1_q : nrd_q;
	end

	// Gradients of the up to three pixels this beat completes
	always_comb begin
		if (at_c0)
			gx_a = dbl(dif(nxt, cur));
		else if (at_cl)
			gx_a = dbl(dif(cur, wprev_q));
		else
			gx_a = dif(nxt, wprev_q);
		gy_a = at_r1 ? dbl(dif(pixel, cur)) : dif(pixel, ord_q);
		gx_b = at_c1 ? dbl(dif(pixel, l0_q)) : dif(pixel, l1_q);
		gy_b = dbl(dif(l0_q, wprev_q));
		gx_c = dbl(dif(pixel, l0_q));
		gy_c = dbl(dif(pixel, cur));
		val_a = r != '0;
		val_b = val_a && at_rl && !at_c0;
		val_c = val_a && at_rl && at_cl;
	end

	// Pack jobs, compacted in result order
	always_comb begin
		job_a = {!(val_b || val_c), RW'(r - RW'(1)), c, gy_a, gx_a};
		job_b = {!val_c, r, CW'(c - CW'(1)), gy_b, gx_b};
		job_c = {1'b1, r, c, gy_c, gx_c};
		push_data = {job_c, (val_b ? job_b : job_c), job_a};
		if (accept && val_a)
			push_num = gmo_pkg::PUSH_W'(1) + gmo_pkg::PUSH_W'(val_b)
				+ gmo_pkg::PUSH_W'(val_c);
		else
			push_num = '0;
	end

	// Row stores: write this column, prefetch the next columns
	always_ff @(posedge clk) begin
		if (accept) begin
			newer_mem[c] <= pixel;
			older_mem[c] <= cur;
			nrd_q        <= newer_mem[c + CW'(2)];
			ord_q        <= older_mem[at_cl ? '0 : c + CW'(1)];
			wprev_q      <= cur;
			wcur_q       <= nxt;
			if (at_c0)
				h0_q <= pixel;
			if (at_c1)
				h1_q <= pixel;
		end
	end

	// Advance raster position and left neighbors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			l0_q  <= '0;
			l1_q  <= '0;
		end else if (accept) begin
			l0_q <= pixel;
			l1_q <= l0_q;
			if (at_cl) begin
				col_q <= '0;
				row_q <= at_rl ? '0 : r + RW'(1);
			end else begin
				col_q <= c + CW'(1);
				row_q <= r;
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/gmo_back.sv */
`default_nettype none
module gmo_back #(
	parameter int MAX_WIDTH  = gmo_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = gmo_pkg::DEF_PIXEL_BITS
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire gmo_pkg::q_status_t                     qstat,
	input  wire logic [2*(PIXEL_BITS+2)+$clog2(MAX_WIDTH)+gmo_pkg::ROW_W:0] job,
	output logic                                        pop,
	output logic                                        res_valid,
	input  wire logic                                   res_ready,
	output logic [PIXEL_BITS+gmo_pkg::ORI_W+$clog2(MAX_WIDTH)+gmo_pkg::ROW_W:0] res_data,
	output logic                                        res_last
);

	localparam int P    = PIXEL_BITS;
	localparam int G    = P + 2;
	localparam int AW   = P + 1;
	localparam int DW   = P + 2;
	localparam int RMW  = P + 3;
	localparam int SQW  = 2*P + 4;
	localparam int SQN  = P + 2;
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = gmo_pkg::ROW_W;
	localparam int N    = gmo_pkg::DIV_STEPS;
	localparam int FR   = gmo_pkg::FRAC;
	localparam int SD   = CW + RW + 6;
	localparam int OW   = P + 1 + gmo_pkg::ORI_W + CW + RW;
	localparam logic [SQW-1:0] MAG_FLOOR =
		SQW'(((64'd1 << (2*P+2)) + 64'd99999999) / 64'd100000000);

	logic adv;
	assign adv = !res_valid || res_ready;
	assign pop = qstat.avail && adv;

	// Unpack the job
	logic signed [G-1:0] j_gx, j_gy;
	logic [CW-1:0] j_col;
	logic [RW-1:0] j_row;
	logic          j_last;
	assign j_gx   = job[G-1:0];
	assign j_gy   = job[2*G-1:G];
	assign j_col  = job[2*G +: CW];
	assign j_row  = job[2*G+CW +: RW];
	assign j_last = job[2*G+CW+RW];

	// Stage 1: magnitudes of the components, ratio operands
	logic          v_s1, gxn_s1, gyn_s1, rneg_s1, dz_s1, last_s1;
	logic [AW-1:0] ax_s1, ay_s1, an_s1;
	logic [DW-1:0] den_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic [AW-1:0] ax, ay;

	always_comb begin
		ax = AW'(j_gx[G-1] ? -j_gx : j_gx);
		ay = AW'(j_gy[G-1] ? -j_gy : j_gy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= pop;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1   <= ax;
			ay_s1   <= ay;
			an_s1   <= (ax > ay) ? ax - ay : ay - ax;
			den_s1  <= DW'(ax) + DW'(ay);
			gxn_s1  <= j_gx[G-1];
			gyn_s1  <= j_gy[G-1];
			rneg_s1 <= j_gx[G-1] ? (ay < ax) : (ax < ay);
			dz_s1   <= (ax == '0) && (ay == '0);
			col_s1  <= j_col;
			row_s1  <= j_row;
			last_s1 <= j_last;
		end
	end

	// Stage 2: squares
	logic              v_s2;
	logic [2*AW-1:0]   sqx_s2, sqy_s2;
	logic [AW-1:0]     an_s2;
	logic [DW-1:0]     den_s2;
	logic [SD-2:0]     side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2  <= ax_s1 * ax_s1;
			sqy_s2  <= ay_s1 * ay_s1;
			an_s2   <= an_s1;
			den_s2  <= den_s1;
			side_s2 <= {col_s1, row_s1, last_s1, gxn_s1, gyn_s1, rneg_s1, dz_s1};
		end
	end

	// Stage 3, iterations: a quotient bit each, a root digit while i < SQN
	logic          it_v_s    [N+1];
	logic [SQW-1:0] it_sv_s  [N+1];
	logic [SQW-1:0] it_sr_s  [N+1];
	logic [RMW-1:0] it_rem_s [N+1];
	logic [N-1:0]  it_q_s    [N+1];
	logic [DW-1:0] it_den_s  [N+1];
	logic [SD-1:0] it_side_s [N+1];
	logic [SQW-1:0] s_sum;

	assign s_sum = SQW'(sqx_s2) + SQW'(sqy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			it_v_s[0] <= 1'b0;
		else if (adv)
			it_v_s[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_sv_s[0]   <= s_sum;
			it_sr_s[0]   <= '0;
			it_rem_s[0]  <= RMW'(an_s2);
			it_q_s[0]    <= '0;
			it_den_s[0]  <= den_s2;
			it_side_s[0] <= {side_s2, s_sum < MAG_FLOOR};
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_it
		logic [SQW-1:0] sv_n, sr_n;
		logic [RMW-1:0] rem_n;
		logic           ge;

		if (i < SQN) begin : g_sq
			localparam logic [SQW-1:0] SBIT = SQW'(1) << (SQW - 2 - 2*i);
			logic [SQW-1:0] trial;
			always_comb begin
				trial = it_sr_s[i] + SBIT;
				if (it_sv_s[i] >= trial) begin
					sv_n = it_sv_s[i] - trial;
					sr_n = (it_sr_s[i] >> 1) + SBIT;
				end else begin
					sv_n = it_sv_s[i];
					sr_n = it_sr_s[i] >> 1;
				end
			end
		end else begin : g_hold
			assign sv_n = it_sv_s[i];
			assign sr_n = it_sr_s[i];
		end

		// Restoring division step
		always_comb begin
			ge    = it_rem_s[i] >= RMW'(it_den_s[i]);
			rem_n = ge ? it_rem_s[i] - RMW'(it_den_s[i]) : it_rem_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				it_v_s[i+1] <= 1'b0;
			else if (adv)
				it_v_s[i+1] <= it_v_s[i];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				it_sv_s[i+1]   <= sv_n;
				it_sr_s[i+1]   <= sr_n;
				it_rem_s[i+1]  <= rem_n << 1;
				it_q_s[i+1]    <= {it_q_s[i][N-2:0], ge};
				it_den_s[i+1]  <= it_den_s[i];
				it_side_s[i+1] <= it_side_s[i];
			end
		end
	end

	// Tail stage 1: ratio, its square, rounded magnitude
	logic [SD-1:0] fs;
	logic          f_mz, f_dz, f_rneg, f_gyn, f_gxn, f_last;
	logic [CW-1:0] f_col;
	logic [RW-1:0] f_row;
	logic [N-1:0]  f_rm;
	logic [P+2:0]  f_rnd;
	assign fs     = it_side_s[N];
	assign f_mz   = fs[0];
	assign f_dz   = fs[1];
	assign f_rneg = fs[2];
	assign f_gyn  = fs[3];
	assign f_gxn  = fs[4];
	assign f_last = fs[5];
	assign f_row  = fs[6 +: RW];
	assign f_col  = fs[6+RW +: CW];
	assign f_rm   = f_dz ? N'(1) << FR : it_q_s[N];
	assign f_rnd  = (P+3)'(it_sr_s[N]) + (P+3)'(1);

	logic          v_t1, rneg_t1, gyn_t1, gxn_t1, last_t1;
	logic [N-1:0]  rm_t1, r2_t1;
	logic [P:0]    mag_t1;
	logic [CW-1:0] col_t1;
	logic [RW-1:0] row_t1;
	logic [2*N-1:0] rr;
	assign rr = f_rm * f_rm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_t1 <= 1'b0;
		else if (adv)
			v_t1 <= it_v_s[N];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rm_t1   <= f_rm;
			r2_t1   <= N'(rr >> FR);
			mag_t1  <= f_mz ? '0 : f_rnd[P+1:1];
			rneg_t1 <= f_rneg || f_dz;
			gyn_t1  <= f_gyn;
			gxn_t1  <= f_gxn;
			last_t1 <= f_last;
			col_t1  <= f_col;
			row_t1  <= f_row;
		end
	end

	// Tail stage 2: polynomial factor
	logic          v_t2, rneg_t2, gyn_t2, gxn_t2, last_t2;
	logic [N-1:0]  rm_t2;
	logic [31:0]   t_t2;
	logic [P:0]    mag_t2;
	logic [CW-1:0] col_t2;
	logic [RW-1:0] row_t2;
	logic [63:0]   kr;
	assign kr = 64'(gmo_pkg::K1) * 64'(r2_t1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_t2 <= 1'b0;
		else if (adv)
			v_t2 <= v_t1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_t2    <= gmo_pkg::K2 - 32'(kr >> FR);
			rm_t2   <= rm_t1;
			mag_t2  <= mag_t1;
			rneg_t2 <= rneg_t1;
			gyn_t2  <= gyn_t1;
			gxn_t2  <= gxn_t1;
			last_t2 <= last_t1;
			col_t2  <= col_t1;
			row_t2  <= row_t1;
		end
	end

	// Tail stage 3: angle offset
	logic          v_t3, rneg_t3, gyn_t3, gxn_t3, last_t3;
	logic [31:0]   p_t3;
	logic [P:0]    mag_t3;
	logic [CW-1:0] col_t3;
	logic [RW-1:0] row_t3;
	logic [63:0]   tp;
	assign tp = 64'(t_t2) * 64'(rm_t2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_t3 <= 1'b0;
		else if (adv)
			v_t3 <= v_t2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_t3    <= 32'(tp >> FR);
			mag_t3  <= mag_t2;
			rneg_t3 <= rneg_t2;
			gyn_t3  <= gyn_t2;
			gxn_t3  <= gxn_t2;
			last_t3 <= last_t2;
			col_t3  <= col_t2;
			row_t3  <= row_t2;
		end
	end

	// Fold into a full turn and round to the output grid
	logic [31:0] base, ang, angr;
	always_comb begin
		base = gxn_t3 ? gmo_pkg::BASE_NEG : gmo_pkg::BASE_POS;
		ang  = rneg_t3 ? base + p_t3 : base - p_t3;
		if (gyn_t3)
			ang = 32'd0 - ang;
		angr = ang + gmo_pkg::ROUND_ORI;
	end

	// Output register
	logic [OW-1:0] o_data_q;
	logic          o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid <= 1'b0;
		else if (adv)
			res_valid <= v_t3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			o_data_q <= {row_t3, col_t3, angr[31:16], mag_t3};
			o_last_q <= last_t3;
		end
	end

	assign res_data = o_data_q;
	assign res_last = o_last_q;

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(o_data_q) && $stable(o_last_q)))
		else $error("result changed while stalled");

	a_pop_only_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> adv)
		else $error("job taken while back end is stalled");

	a_stage_feed: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && pop) |=> v_s1)
		else $error("taken job did not enter the pipeline");

endmodule
`default_nettype wire

/* hdl/gradient_magnitude_orientation.sv */
// Gradient magnitude and orientation of one image plane.
//
// Slave stream (s_*): pixels of one plane in raster order, one per beat.
// Master stream (m_*): results, one per beat; m_tlast marks the last result
// caused by one input beat. Results trail the input by one row; on the last
// row the first pixel completes one result, every other pixel two and the
// final pixel three.
// Config channel (cfg_*): register 0 frame_width, register 1 frame_height;
// always ready. It must be written only while the block is idle; the block does not enforce this.
// Throughput: one pixel per cycle on interior rows while m_tready is high, set by the
// back-end pipeline taking one job a cycle; on the last row pixels are taken more slowly.
// A pixel's first result passes from its acceptance through the job queue, three
// setup stages, 31 iteration stages of the shared root/ratio pipeline, three
// polynomial stages and the output register; any further results of the same
// pixel follow one per cycle while m_tready is high.
// Reset clears the raster position, the job queue and all valid bits; row
// store contents are not cleared. When m_tready is low the back end holds,
// the 8-entry job queue fills, and s_tready drops once fewer than three
// entries are free.
`default_nettype none
module gradient_magnitude_orientation #(
	parameter int MAX_WIDTH  = gmo_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = gmo_pkg::DEF_PIXEL_BITS
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// pixel
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	input  wire logic [((PIXEL_BITS+7)/8)*8-1:0]        s_tdata,
	// magnitude, orientation, column, row
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	output logic [((PIXEL_BITS+gmo_pkg::ORI_W+$clog2(MAX_WIDTH)+gmo_pkg::ROW_W+8)/8)*8-1:0]
	                                                    m_tdata,
	output logic                                        m_tlast,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [gmo_pkg::REG_IDX_W-1:0]          cfg_index,
	input  wire logic [gmo_pkg::CFG_DATA_W-1:0]         cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = gmo_pkg::ROW_W;
	localparam int JW = 2*(PIXEL_BITS+2) + CW + RW + 1;
	localparam int OW = PIXEL_BITS + 1 + gmo_pkg::ORI_W + CW + RW;
	localparam int TW = ((PIXEL_BITS+gmo_pkg::ORI_W+CW+RW+8)/8)*8;

	logic [gmo_pkg::FW_BITS-1:0] frame_width_q;
	logic [gmo_pkg::FH_BITS-1:0] frame_height_q;
	logic [31:0] fw_x, fh_x, w_eff, h_eff;
	logic [CW-1:0] wm1;
	logic [RW-1:0] hm1;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= gmo_pkg::FW_RESET;
			frame_height_q <= gmo_pkg::FH_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				gmo_pkg::REG_FRAME_WIDTH: frame_width_q <= cfg_data[gmo_pkg::FW_BITS-1:0];
				gmo_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturate frame size to the supported range
	always_comb begin
		fw_x = 32'(frame_width_q);
		fh_x = 32'(frame_height_q);
		if (fw_x < 32'd2)
			w_eff = 32'd2;
		else if (fw_x > 32'(MAX_WIDTH))
			w_eff = 32'(MAX_WIDTH);
		else
			w_eff = fw_x;
		if (fh_x < 32'd2)
			h_eff = 32'd2;
		else if (fh_x > 32'(gmo_pkg::MAX_HEIGHT))
			h_eff = 32'(gmo_pkg::MAX_HEIGHT);
		else
			h_eff = fh_x;
		wm1 = CW'(w_eff - 32'd1);
		hm1 = RW'(h_eff - 32'd1);
	end

	gmo_pkg::q_status_t                       qstat;
	logic [gmo_pkg::PUSH_W-1:0]               push_num;
	logic [gmo_pkg::MAX_PER_ITEM*JW-1:0]      push_data;
	logic [JW-1:0]                            head;
	logic                                     pop;
	logic [OW-1:0]                            res_data;

	gmo_front #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (s_tvalid),
		.pix_ready (s_tready),
		.pixel     (s_tdata[PIXEL_BITS-1:0]),
		.wm1       (wm1),
		.hm1       (hm1),
		.qstat     (qstat),
		.push_num  (push_num),
		.push_data (push_data)
	);

	gmo_queue #(.DATA_W(JW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_num  (push_num),
		.push_data (push_data),
		.pop       (pop),
		.status    (qstat),
		.head      (head)
	);

	gmo_back #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.job       (head),
		.pop       (pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_data  (res_data),
		.res_last  (m_tlast)
	);

	assign m_tdata = TW'(res_data);

endmodule
`default_nettype wire

/* verif/gradient_magnitude_orientation_tb.sv */
`default_nettype none
module gradient_magnitude_orientation_tb;

	localparam int PERIOD  = 12;
	localparam int MAG_LSB = 0;
	localparam int ORI_LSB = 17;
	localparam int COL_LSB = 33;
	localparam int ROW_LSB = 43;
	localparam longint unsigned MAG_FLOOR = 172;

	typedef struct {
		logic [16:0] mag;
		logic [15:0] ori;
		logic [9:0]  col;
		logic [11:0] row;
		logic        last;
	} gradient_t;

	typedef enum {PAT_RANDOM, PAT_FLAT, PAT_CHECKER, PAT_FAINT, PAT_RAMP} pattern_t;

	// Predicts every result beat from the accepted pixels and checks the output
	class gradient_scoreboard;
		gradient_t   pending_q[$];
		logic [10:0] fw;
		logic [12:0] fh;
		logic [15:0] older_row[gmo_pkg::DEF_MAX_WIDTH];
		logic [15:0] newer_row[gmo_pkg::DEF_MAX_WIDTH];
		int          col_cnt;
		int          row_cnt;
		logic [15:0] left_px[2];
		int          errors;
		int          checked;

		function new();
			fw = gmo_pkg::FW_RESET;
			fh = gmo_pkg::FH_RESET;
			foreach (older_row[i]) begin
				older_row[i] = '0;
				newer_row[i] = '0;
			end
			col_cnt = 0;
			row_cnt = 0;
			left_px[0] = '0;
			left_px[1] = '0;
			errors = 0;
			checked = 0;
		endfunction

		function void configure(logic [gmo_pkg::REG_IDX_W-1:0] idx,
			logic [gmo_pkg::CFG_DATA_W-1:0] val);
			if (idx == gmo_pkg::REG_FRAME_WIDTH)
				fw = val[gmo_pkg::FW_BITS-1:0];
			else if (idx == gmo_pkg::REG_FRAME_HEIGHT)
				fh = val[gmo_pkg::FH_BITS-1:0];
		endfunction

		function longint unsigned root_floor(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function logic [16:0] mag_of(longint gx, longint gy);
			longint unsigned ax, ay, s;
			ax = gx < 0 ? -gx : gx;
			ay = gy < 0 ? -gy : gy;
			s = ax * ax + ay * ay;
			if (s < MAG_FLOOR)
				return '0;
			return 17'((root_floor(s) + 1) >> 1);
		endfunction

		function logic [15:0] angle_of(longint gx, longint gy);
			longint a, num, den;
			longint unsigned rm, r2, t, p, an;
			logic rneg;
			logic [31:0] ang;
			a = gy < 0 ? -gy : gy;
			if (gx >= 0) begin
				num = gx - a;
				den = gx + a;
			end else begin
				num = gx + a;
				den = a - gx;
			end
			if (den == 0) begin
				// zero gradient: ratio pinned to minus one
				rm = 64'd1 << gmo_pkg::FRAC;
				rneg = 1'b1;
			end else begin
				an = num < 0 ? -num : num;
				rm = (an << gmo_pkg::FRAC) / longint'(den);
				rneg = num < 0;
			end
			r2 = (rm * rm) >> gmo_pkg::FRAC;
			t = longint'(gmo_pkg::K2) - ((longint'(gmo_pkg::K1) * r2) >> gmo_pkg::FRAC);
			p = (t * rm) >> gmo_pkg::FRAC;
			ang = gx >= 0 ? gmo_pkg::BASE_POS : gmo_pkg::BASE_NEG;
			if (rneg)
				ang = ang + p[31:0];
			else
				ang = ang - p[31:0];
			if (gy < 0)
				ang = 32'd0 - ang;
			ang = ang + gmo_pkg::ROUND_ORI;
			return ang[31:16];
		endfunction

		function void add_result(longint gx, longint gy, int c, int r);
			gradient_t g;
			g.mag = mag_of(gx, gy);
			g.ori = angle_of(gx, gy);
			g.col = 10'(c);
			g.row = 12'(r);
			g.last = 1'b0;
			pending_q.push_back(g);
		endfunction

		function void note_pixel(logic [15:0] pix);
			int w, h, c, r, n;
			longint px, gx, gy;
			w = fw;
			h = fh;
			n = 0;
			if (w < 2) w = 2;
			if (w > gmo_pkg::DEF_MAX_WIDTH) w = gmo_pkg::DEF_MAX_WIDTH;
			if (h < 2) h = 2;
			if (h > gmo_pkg::MAX_HEIGHT) h = gmo_pkg::MAX_HEIGHT;
			c = col_cnt > w - 1 ? w - 1 : col_cnt;
			r = row_cnt > h - 1 ? h - 1 : row_cnt;
			px = pix;
			if (r >= 1) begin
				// pixel above the input
				if (c == 0)
					gx = 2 * (longint'(newer_row[1]) - longint'(newer_row[0]));
				else if (c == w - 1)
					gx = 2 * (longint'(newer_row[w-1]) - longint'(newer_row[w-2]));
				else
					gx = longint'(newer_row[c+1]) - longint'(newer_row[c-1]);
				if (r == 1)
					gy = 2 * (px - longint'(newer_row[c]));
				else
					gy = px - longint'(older_row[c]);
				add_result(gx, gy, c, r - 1);
				n++;
				if (r == h - 1) begin
					// last-row pixel to the left of the input
					if (c >= 1) begin
						if (c == 1)
							gx = 2 * (px - longint'(left_px[0]));
						else
							gx = px - longint'(left_px[1]);
						gy = 2 * (longint'(left_px[0]) - longint'(newer_row[c-1]));
						add_result(gx, gy, c - 1, r);
						n++;
					end
					// final pixel of the plane
					if (c == w - 1) begin
						gx = 2 * (px - longint'(left_px[0]));
						gy = 2 * (px - longint'(newer_row[c]));
						add_result(gx, gy, c, r);
						n++;
					end
				end
			end
			// shift the row stores
			if (c >= 1) begin
				older_row[c-1] = newer_row[c-1];
				newer_row[c-1] = left_px[0];
			end
			if (c == w - 1) begin
				older_row[c] = newer_row[c];
				newer_row[c] = pix;
			end
			left_px[1] = left_px[0];
			left_px[0] = pix;
			if (c == w - 1) begin
				col_cnt = 0;
				row_cnt = (r == h - 1) ? 0 : r + 1;
			end else begin
				col_cnt = c + 1;
				row_cnt = r;
			end
			if (n > 0)
				pending_q[$].last = 1'b1;
		endfunction

		function void check_beat(logic [55:0] data, logic last);
			gradient_t g;
			checked++;
			if (pending_q.size() == 0) begin
				$error("unexpected result beat data=%h last=%b", data, last);
				errors++;
				return;
			end
			g = pending_q.pop_front();
			if (data[MAG_LSB +: 17] !== g.mag) begin
				$error("magnitude: expected %0d, got %0d", g.mag, data[MAG_LSB +: 17]);
				errors++;
			end
			if (data[ORI_LSB +: 16] !== g.ori) begin
				$error("orientation: expected %0d, got %0d", g.ori, data[ORI_LSB +: 16]);
				errors++;
			end
			if (data[COL_LSB +: 10] !== g.col) begin
				$error("column: expected %0d, got %0d", g.col, data[COL_LSB +: 10]);
				errors++;
			end
			if (data[ROW_LSB +: 12] !== g.row) begin
				$error("row: expected %0d, got %0d", g.row, data[ROW_LSB +: 12]);
				errors++;
			end
			if (last !== g.last) begin
				$error("last_of_run: expected %0b, got %0b", g.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return pending_q.size();
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [15:0]                    s_tdata;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [55:0]                    m_tdata;
	logic                           m_tlast;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [gmo_pkg::REG_IDX_W-1:0]  cfg_index;
	logic [gmo_pkg::CFG_DATA_W-1:0] cfg_data;

	gradient_scoreboard sb;
	bit  tx_idle;
	bit  rx_idle;
	bit  hold_req;
	int  pixels_sent;
	int  frames_run;

	gradient_magnitude_orientation uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #(PERIOD / 2) clk = ~clk;

	// Watch all three channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_beat(m_tdata, m_tlast);
			if (s_tvalid && s_tready)
				sb.note_pixel(s_tdata);
			if (cfg_valid && cfg_ready)
				sb.configure(cfg_index, cfg_data);
		end
	end

	// Receiver: random hold-off per beat, or one long stall on request
	initial begin
		int wait_n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (300) @(negedge clk);
				hold_req = 1'b0;
			end
			wait_n = rx_idle ? $urandom_range(0, 19) : 0;
			if (wait_n > 0) begin
				m_tready = 1'b0;
				repeat (wait_n - 1) @(negedge clk);
				@(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		#(PERIOD * 4000000);
		$display("TB_ERROR");
		$finish;
	end

	task automatic write_reg(logic [gmo_pkg::REG_IDX_W-1:0] idx,
		logic [gmo_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Offer one pixel; valid stays high across back-to-back beats
	task automatic send_pixel(logic [15:0] pix);
		int wait_n;
		wait_n = tx_idle ? $urandom_range(0, 19) : 0;
		if (wait_n > 0) begin
			s_tvalid = 1'b0;
			repeat (wait_n) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = pix;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		pixels_sent++;
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (sb.pending() != 0 || hold_req)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	function automatic int clamp(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Run one plane with the given register values and pattern
	task automatic run_frame(int w_reg, int h_reg, pattern_t pat, bit pause_mid);
		int w, h, base, slope_x, slope_y, v;
		w = clamp(w_reg, 2, gmo_pkg::DEF_MAX_WIDTH);
		h = clamp(h_reg, 2, gmo_pkg::MAX_HEIGHT);
		write_reg(gmo_pkg::REG_FRAME_WIDTH, gmo_pkg::CFG_DATA_W'(w_reg));
		write_reg(gmo_pkg::REG_FRAME_HEIGHT, gmo_pkg::CFG_DATA_W'(h_reg));
		base = $urandom_range(0, 65535);
		slope_x = $urandom_range(0, 8000) - 4000;
		slope_y = $urandom_range(0, 8000) - 4000;
		@(negedge clk);
		for (int r = 0; r < h; r++) begin
			for (int c = 0; c < w; c++) begin
				case (pat)
					PAT_FLAT:    v = base;
					PAT_CHECKER: v = ((r + c) % 2) ? 65535 : 0;
					PAT_FAINT:   v = 30000 + $urandom_range(0, 9);
					PAT_RAMP:    v = clamp(base + slope_x * c + slope_y * r
						+ $urandom_range(0, 63), 0, 65535);
					default:     v = $urandom_range(0, 65535);
				endcase
				if (pause_mid && r == h / 2 && c == 0) begin
					// let every result of the earlier rows come out
					s_tvalid = 1'b0;
					while (sb.pending() != 0)
						@(negedge clk);
				end
				send_pixel(16'(v));
			end
		end
		frames_run++;
		drain();
	endtask

	initial begin
		int pick;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		hold_req = 1'b0;
		pixels_sent = 0;
		frames_run = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed: flat plane, full-scale checker, near-threshold gradients
		run_frame(2, 2, PAT_FLAT, 0);
		run_frame(3, 2, PAT_CHECKER, 0);
		run_frame(4, 3, PAT_FAINT, 1);

		// Register values below range saturate to the smallest plane
		run_frame(0, 1, PAT_RANDOM, 0);
		tx_idle = 1'b0;
		rx_idle = 1'b0;

		// Long receiver stall while the sender keeps offering
		hold_req = 1'b1;
		run_frame(16, 8, PAT_RAMP, 0);

		// Random planes, small sizes, idling toggled per plane
		pick = 0;
		while (pixels_sent < 300) begin
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 9))
				0:       run_frame($urandom_range(2, 16), $urandom_range(2, 8), PAT_FAINT, 0);
				1:       run_frame($urandom_range(2, 16), $urandom_range(2, 8), PAT_CHECKER, 0);
				2, 3, 4: run_frame($urandom_range(2, 16), $urandom_range(2, 8), PAT_RAMP,
					pick == 0);
				default: run_frame($urandom_range(2, 16), $urandom_range(2, 8), PAT_RANDOM, 0);
			endcase
			pick++;
		end
		drain();

		$display("Covered %0d planes, %0d pixels and %0d result beats,", frames_run,
			pixels_sent, sb.checked);
		$display("with small planes, saturated registers, stalls and idle gaps.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
